// ----- rtl/rate_monotonic_run_queue_macros.svh -----
// Assertion macros for the run queue.
`ifndef RATE_MONOTONIC_RUN_QUEUE_MACROS_SVH
`define RATE_MONOTONIC_RUN_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define RMRQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMRQ_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMRQ_ASSERT(label, clk, rst_n, prop, msg)
`define RMRQ_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

// ----- rtl/rmrq_pkg.sv -----
// Shared types and codes for the run queue.
package rmrq_pkg;
  localparam int unsigned OpW = 2;
  localparam logic [OpW-1:0] OP_ENQ = 2'd0;
  localparam logic [OpW-1:0] OP_DEQ = 2'd1;
  localparam logic [OpW-1:0] OP_DET = 2'd2;
  localparam logic [OpW-1:0] OP_QRY = 2'd3;
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;
  localparam int unsigned IdW = 6;
  localparam int unsigned LvW = 3;
  localparam int unsigned ValW = 64;
  localparam int unsigned StampW = 32;
  localparam int unsigned CntW = 7;
  localparam int unsigned InDataW = 144;
  localparam int unsigned OutDataW = 80;

  typedef struct packed {
    logic [ValW-1:0]   period;
    logic [StampW-1:0] stamp;
    logic [LvW-1:0]    level;
  } key_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdW-1:0]  gid;
    logic [ValW-1:0] slice;
    logic            preempt;
    logic [CntW-1:0] count;
  } result_t;
endpackage

// ----- rtl/rate_monotonic_run_queue.sv -----
// Rate-monotonic run queue: top level with the sequencer and per-level counts.
// Enqueue, detach and query pass through the S_RD and S_FIN states from acceptance
// to result; a dequeue with entries queued walks every entry slot through the key
// memory's single read port, one slot a cycle, then goes through S_SL and S_FIN. One item
// is in work at a time; the next is taken once the result register is free.
// Queued flags sit in flip-flops and entry levels share the key memory; no
// clearing pass.
module rate_monotonic_run_queue #(
  parameter int unsigned ENTRIES = 64,
  parameter int unsigned LEVELS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // op[1:0], vcpu_id[7:2], level[10:8], period[74:11], slice_in[138:75], zero pad
  input  logic [rmrq_pkg::InDataW-1:0]    in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[1:0], granted_id[7:2], slice_out[71:8], preempt_needed[72],
  // level_count[79:73]
  output logic [rmrq_pkg::OutDataW-1:0]   out_tdata
);
  import rmrq_pkg::*;
  `include "rate_monotonic_run_queue_macros.svh"

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned SCW = AW + 1;
  localparam int unsigned CW = AW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SL   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [OpW-1:0]    op_r;
  logic [IdW-1:0]    id_r;
  logic [LW-1:0]     lv_r;
  logic [ValW-1:0]   per_r;
  logic [ValW-1:0]   sl_r;
  logic [StampW-1:0] arr_r;
  logic [ENTRIES-1:0] q_r;
  logic [CW-1:0]     cnt_r [LEVELS];
  logic [SCW-1:0]    scan_r;
  logic              found_r;
  logic [AW-1:0]     best_r;
  key_t              bkey_r;
  logic [AW-1:0]     chk_r;
  logic              chk_v_r;
  logic [1:0]        st_r;
  result_t           res_r;
  logic              ov_r;

  logic              kwe, swe;
  logic [AW-1:0]     kra, sra;
  key_t              krd;
  logic [ValW-1:0]   srd;
  logic              id_ok;
  logic [AW-1:0]     id_a;
  logic [LW-1:0]     det_lv;
  logic [LW-1:0]     top_lv;
  logic              any_q;
  logic [LW-1:0]     rep_lv;
  logic              pre;
  logic [StampW-1:0] age_i, age_b;

  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign out_tvalid = ov_r;
  assign out_tdata = {res_r.count, res_r.preempt, res_r.slice, res_r.gid, res_r.status};

  assign id_ok = ({{(32-IdW){1'b0}}, id_r} < ENTRIES);
  assign id_a = AW'(id_r);
  assign det_lv = LW'(krd.level);

  always_comb begin
    top_lv = '0;
    any_q = 1'b0;
    for (int p = 0; p < LEVELS; p++) begin
      if (cnt_r[p] != '0) begin
        top_lv = LW'(p);
        any_q = 1'b1;
      end
    end
  end

  assign kwe = (state_r == S_RD) && (op_r == OP_ENQ) && id_ok && !q_r[id_a];
  assign swe = kwe;
  assign kra = (state_r == S_SCAN) ? scan_r[AW-1:0] : AW'(in_tdata[7:2]);
  assign sra = best_r;

  rmrq_key_mem #(.AW(AW)) u_key (
    .clk(clk), .we(kwe), .waddr(id_a),
    .wdata('{period: per_r, stamp: arr_r, level: LvW'(lv_r)}), .raddr(kra), .rdata(krd)
  );
  rmrq_slice_mem #(.AW(AW)) u_slice (
    .clk(clk), .we(swe), .waddr(id_a), .wdata(sl_r), .raddr(sra), .rdata(srd)
  );

  assign age_i = arr_r - krd.stamp;
  assign age_b = arr_r - bkey_r.stamp;

  always_comb begin
    rep_lv = lv_r;
    pre = 1'b0;
    for (int p = 0; p < LEVELS; p++) begin
      if (LW'(p) > rep_lv && cnt_r[p] != '0) begin
        pre = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid && in_tready) state_nxt = S_RD;
      S_RD: state_nxt = (op_r == OP_DEQ && any_q) ? S_SCAN : S_FIN;
      S_SCAN: if (!chk_v_r && scan_r == SCW'(ENTRIES)) state_nxt = S_SL;
      S_SL: state_nxt = S_FIN;
      S_FIN: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      q_r <= '0;
      arr_r <= '0;
      for (int p = 0; p < LEVELS; p++) cnt_r[p] <= '0;
      chk_v_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_tready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r <= in_tdata[1:0];
            id_r <= in_tdata[7:2];
            lv_r <= (32'(in_tdata[10:8]) >= LEVELS) ? LW'(LEVELS-1) : LW'(in_tdata[10:8]);
            per_r <= in_tdata[74:11];
            sl_r <= in_tdata[138:75];
          end
        end
        S_RD: begin
          scan_r <= '0;
          chk_v_r <= 1'b0;
          found_r <= 1'b0;
          res_r.gid <= '0;
          res_r.slice <= '0;
          case (op_r)
            OP_ENQ: begin
              if (!id_ok || q_r[id_a]) begin
                st_r <= ST_ERR;
              end else begin
                st_r <= ST_OK;
                q_r[id_a] <= 1'b1;
                arr_r <= arr_r + 1'b1;
                cnt_r[lv_r] <= cnt_r[lv_r] + 1'b1;
              end
            end
            OP_DEQ: begin
              if (!any_q) begin
                st_r <= ST_EMPTY;
              end else begin
                st_r <= ST_OK;
                lv_r <= top_lv;
              end
            end
            OP_DET: begin
              if (!id_ok || !q_r[id_a]) begin
                st_r <= ST_ERR;
              end else begin
                st_r <= ST_OK;
                q_r[id_a] <= 1'b0;
                lv_r <= det_lv;
                cnt_r[det_lv] <= cnt_r[det_lv] - 1'b1;
              end
            end
            default: st_r <= ST_OK;
          endcase
        end
        S_SCAN: begin
          if (scan_r != SCW'(ENTRIES)) begin
            scan_r <= scan_r + 1'b1;
            chk_r <= scan_r[AW-1:0];
            chk_v_r <= q_r[scan_r[AW-1:0]];
          end else begin
            chk_v_r <= 1'b0;
          end
          if (chk_v_r && krd.level == LvW'(lv_r)) begin
            if (!found_r || krd.period < bkey_r.period ||
                (krd.period == bkey_r.period && age_i > age_b)) begin
              found_r <= 1'b1;
              best_r <= chk_r;
              bkey_r <= krd;
            end
          end
        end
        S_SL: begin
          q_r[best_r] <= 1'b0;
          cnt_r[lv_r] <= cnt_r[lv_r] - 1'b1;
          res_r.gid <= IdW'(best_r);
        end
        S_FIN: begin
          ov_r <= 1'b1;
          res_r.status <= st_r;
          if (op_r == OP_DEQ && st_r == ST_OK) res_r.slice <= srd;
          res_r.preempt <= pre;
          res_r.count <= CntW'(cnt_r[rep_lv]);
        end
        default: ;
      endcase
    end
  end

  `RMRQ_ASSERT(a_no_accept_busy, clk, rst_n, (state_r != S_IDLE) |-> !in_tready, "accept while busy")
  `RMRQ_ASSERT(a_result_after_fin, clk, rst_n, (state_r == S_FIN) |=> out_tvalid, "result lost")
  `RMRQ_ASSERT(a_enq_once, clk, rst_n, kwe |=> q_r[$past(id_a)], "enqueue flag not set")
  `RMRQ_ASSERT_RST(a_reset_idle, clk, !rst_n |=> (state_r == S_IDLE && !out_tvalid), "reset state")
endmodule

// ----- rtl/rmrq_key_mem.sv -----
// Per-entry key store: period, arrival stamp and level, one read and one write port.
module rmrq_key_mem #(
  parameter int unsigned AW = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  rmrq_pkg::key_t    wdata,
  input  logic [AW-1:0]     raddr,
  output rmrq_pkg::key_t    rdata
);
  import rmrq_pkg::*;
  key_t mem [2**AW];
  key_t rdata_r;
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
  assign rdata = rdata_r;
endmodule

// ----- rtl/rmrq_slice_mem.sv -----
// Per-entry time slice store, one read and one write port.
module rmrq_slice_mem #(
  parameter int unsigned AW = 6
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [rmrq_pkg::ValW-1:0]   wdata,
  input  logic [AW-1:0]               raddr,
  output logic [rmrq_pkg::ValW-1:0]   rdata
);
  import rmrq_pkg::*;
  logic [ValW-1:0] mem [2**AW];
  logic [ValW-1:0] rdata_r;
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
  assign rdata = rdata_r;
endmodule
